FILE: hdl/akar_pkg.sv
// Shared types, constants and key classification for the analog keypad auto-repeat unit.
package akar_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned KeyW    = 3;
  localparam int unsigned CntW    = 8;
  localparam int unsigned PeriodW = 15;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 15;

  typedef enum logic [KeyW-1:0] {
    KeyNone     = 3'd0,
    KeyRight    = 3'd1,
    KeyUp       = 3'd2,
    KeyDown     = 3'd3,
    KeyLeft     = 3'd4,
    KeySelect   = 3'd5,
    KeyHeldWait = 3'd6
  } key_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSampleCount    = 2'd0,
    CfgRepeatInterval = 2'd1,
    CfgRepeatDelay    = 2'd2
  } cfg_idx_e;

  localparam logic [SampleW-1:0] MinIdle      = 10'd1023;
  localparam logic [SampleW-1:0] ThreshNone   = 10'd1000;
  localparam logic [SampleW-1:0] ThreshSelect = 10'd700;
  localparam logic [SampleW-1:0] ThreshLeft   = 10'd450;
  localparam logic [SampleW-1:0] ThreshDown   = 10'd300;
  localparam logic [SampleW-1:0] ThreshUp     = 10'd100;

  localparam logic [CntW-1:0]    SampleCountRst    = 8'd5;
  localparam logic [PeriodW-1:0] RepeatIntervalRst = 15'd200;
  localparam logic [PeriodW-1:0] RepeatDelayRst    = 15'd500;

  function automatic key_e classify(input logic [SampleW-1:0] v);
    key_e k;
    if (v > ThreshNone) k = KeyNone;
    else if (v > ThreshSelect) k = KeySelect;
    else if (v > ThreshLeft) k = KeyLeft;
    else if (v > ThreshDown) k = KeyDown;
    else if (v > ThreshUp) k = KeyUp;
    else k = KeyRight;
    return k;
  endfunction

endpackage

FILE: hdl/analog_keypad_autorepeat_unit.sv
// Analog keypad reader: group minimum, ladder classification and key auto-repeat.
//
// Takes one ADC word per cycle. Each word passes an input register, then one pass of logic
// (minimum update, group count, ladder thresholds, repeat timing against the last report
// time) that writes the state and, when the word closes a group, the result register.
// A result is registered from its staged closing word; input accepts a word every
// cycle and stalls only while a result sits in the output register with the consumer not
// ready and the staged word would close another group. Configuration writes are taken in
// any cycle and should be made only while the unit is idle.
module analog_keypad_autorepeat_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [akar_pkg::SampleW-1:0]  sample_i,
  input  logic [akar_pkg::TimeW-1:0]    now_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [akar_pkg::KeyW-1:0]     key_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [akar_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [akar_pkg::CfgDataW-1:0] cfg_data_i
);

  // configuration
  logic [akar_pkg::CntW-1:0]    sample_count_q;
  logic [akar_pkg::PeriodW-1:0] repeat_interval_q;
  logic [akar_pkg::PeriodW-1:0] repeat_delay_q;

  // input register
  logic                         in_valid_q;
  logic [akar_pkg::SampleW-1:0] sample_q;
  logic [akar_pkg::TimeW-1:0]   now_q;

  // keypad state
  logic [akar_pkg::SampleW-1:0] min_q, min_d;
  logic [akar_pkg::CntW-1:0]    cnt_q, cnt_d;
  akar_pkg::key_e               last_key_q, last_key_d;
  logic [akar_pkg::TimeW-1:0]   report_time_q, report_time_d;
  logic                         repeated_q, repeated_d;

  // result register
  logic                         out_valid_q;
  akar_pkg::key_e               key_q, key_d;

  logic [akar_pkg::SampleW-1:0] min_new;
  logic [akar_pkg::CntW-1:0]    cnt_new;
  logic                         group_done;
  logic                         out_free;
  logic                         advance;
  akar_pkg::key_e               key_class;
  logic [akar_pkg::TimeW-1:0]   since_interval;
  logic [akar_pkg::TimeW-1:0]   since_delay;
  logic                         wait_interval;
  logic                         wait_delay;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q    <= akar_pkg::SampleCountRst;
      repeat_interval_q <= akar_pkg::RepeatIntervalRst;
      repeat_delay_q    <= akar_pkg::RepeatDelayRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        akar_pkg::CfgSampleCount:    sample_count_q    <= cfg_data_i[akar_pkg::CntW-1:0];
        akar_pkg::CfgRepeatInterval: repeat_interval_q <= cfg_data_i;
        akar_pkg::CfgRepeatDelay:    repeat_delay_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // group bookkeeping on the staged word
  assign min_new    = (sample_q < min_q) ? sample_q : min_q;
  assign cnt_new    = cnt_q + 1'b1;
  assign group_done = (cnt_new == '0) || (cnt_new >= sample_count_q);
  assign key_class  = akar_pkg::classify(min_new);

  assign since_interval = now_q - {{(akar_pkg::TimeW-akar_pkg::PeriodW){1'b0}}, repeat_interval_q};
  assign since_delay    = now_q - {{(akar_pkg::TimeW-akar_pkg::PeriodW){1'b0}}, repeat_delay_q};
  assign wait_interval  = since_interval < report_time_q;
  assign wait_delay     = !repeated_q && (since_delay < report_time_q);

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (out_free || !group_done);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    min_d         = min_q;
    cnt_d         = cnt_q;
    last_key_d    = last_key_q;
    report_time_d = report_time_q;
    repeated_d    = repeated_q;
    key_d         = key_q;
    if (advance) begin
      if (!group_done) begin
        min_d = min_new;
        cnt_d = cnt_new;
      end else begin
        min_d = akar_pkg::MinIdle;
        cnt_d = '0;
        if (key_class == akar_pkg::KeyNone) begin
          // release: keep report time and repeat flag
          last_key_d = akar_pkg::KeyNone;
          key_d      = akar_pkg::KeyNone;
        end else if (key_class == last_key_q) begin
          if (wait_interval || wait_delay) begin
            key_d = akar_pkg::KeyHeldWait;
          end else begin
            repeated_d    = 1'b1;
            report_time_d = now_q;
            key_d         = key_class;
          end
        end else begin
          last_key_d    = key_class;
          repeated_d    = 1'b0;
          report_time_d = now_q;
          key_d         = key_class;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      min_q         <= akar_pkg::MinIdle;
      cnt_q         <= '0;
      last_key_q    <= akar_pkg::KeyNone;
      report_time_q <= '0;
      repeated_q    <= 1'b0;
      key_q         <= akar_pkg::KeyNone;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance && group_done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      min_q         <= min_d;
      cnt_q         <= cnt_d;
      last_key_q    <= last_key_d;
      report_time_q <= report_time_d;
      repeated_q    <= repeated_d;
      key_q         <= key_d;
    end
  end

  // staged word payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      sample_q <= sample_i;
      now_q    <= now_ms_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_o       = key_q;

endmodule

FILE: hdl/akar_checker.sv
// Port-level checker for the analog keypad auto-repeat unit, bound to the top level.
module akar_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [akar_pkg::KeyW-1:0]     key_o,
  input logic                          cfg_ready_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(key_o))
    else $error("result word changed while stalled");

  // input backpressure comes only from a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked result");

  // no unused key code on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> key_o != 3'd7)
    else $error("undefined key code");

  // configuration port never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i || !in_valid_i |-> cfg_ready_o)
    else $error("configuration port stalled");

endmodule

bind analog_keypad_autorepeat_unit akar_checker u_akar_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .key_o       (key_o),
  .cfg_ready_o (cfg_ready_o)
);
